// ----- rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps

package jsu_pkg;

   // most results one source byte can cause
   localparam int RUN_SLOTS = 5;

   // hard ceiling on the per-string output length
   localparam int MAX_FIELD_BYTES = 1024;

   // every result caused by one source byte; the closing word, if any, is the last slot
   typedef struct packed {
      logic [2:0]                     cnt;
      logic                           fin;
      logic                           fovf;
      logic [RUN_SLOTS-1:0][7:0]      bytes;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ----- rtl/json_string_unescape_utf8_top.sv -----
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_in_byte[7:0]
// rsp      out        rsp_valid / rsp_stall  out_byte, byte_valid, string_end,
//                                            overflow_flag, run_last
// csr      in         csr_valid / csr_ready  csr_max_length[9:0]
//
// The front decodes one source byte per cycle and writes all of its result words
// as one run into a RUN_DEPTH-entry run queue; req_stall is high only while that
// queue is full. The drain register sends one word per cycle while rsp_stall is
// low, so an item with k results (k from 0 to 5) occupies the output for k words.
// Synchronous active-high reset clears scan state, queue and drain; max_length
// resets to 1023. csr_ready is always high.
`timescale 1ns / 1ps

module json_string_unescape_utf8_top #(
   parameter int RUN_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_string_end,
   output logic        rsp_overflow_flag,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_max_length
);

   logic [9:0] max_length_ff;

   logic                     push;
   logic                     pop;
   jsu_pkg::run_type         push_run;
   jsu_pkg::run_type         pop_run;
   jsu_pkg::fifo_status_type fifo_stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= 10'd1023;
      end else if (csr_valid && csr_ready) begin
         max_length_ff <= csr_max_length;
      end
   end

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .max_length  (max_length_ff),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_run    (push_run)
   );

   jsu_run_fifo #(
      .DEPTH (RUN_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .pop_run  (pop_run),
      .stat     (fifo_stat)
   );

   jsu_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .fifo_stat         (fifo_stat),
      .pop               (pop),
      .pop_run           (pop_run),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_string_end    (rsp_string_end),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

// ----- rtl/jsu_front.sv -----
`timescale 1ns / 1ps

module jsu_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   input  logic [9:0]                max_length,
   input  jsu_pkg::fifo_status_type  fifo_stat,
   output logic                      push,
   output jsu_pkg::run_type          push_run
);

   localparam logic [2:0] MODE_NORMAL       = 3'd0;
   localparam logic [2:0] MODE_ESC          = 3'd1;
   localparam logic [2:0] MODE_HI           = 3'd2;
   localparam logic [2:0] MODE_AFTER_HI     = 3'd3;
   localparam logic [2:0] MODE_AFTER_HI_ESC = 3'd4;
   localparam logic [2:0] MODE_LO           = 3'd5;
   localparam logic [2:0] MODE_SKIP         = 3'd6;
   localparam logic [2:0] MODE_SKIP_ESC     = 3'd7;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   localparam int CAP_CEIL =
      (jsu_pkg::MAX_FIELD_BYTES - 1 < 1023) ? jsu_pkg::MAX_FIELD_BYTES - 1 : 1023;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] acc;
      logic [2:0]  seen;
      logic [3:0]  hcase;
      logic [9:0]  phigh;
      logic [9:0]  bw;
      logic        ovf;
   } scan_type;

   typedef struct packed {
      scan_type          st;
      jsu_pkg::run_type  run;
   } ctx_type;

   function automatic ctx_type put_byte(ctx_type c, logic [7:0] b);
      if (c.run.cnt < 3'(jsu_pkg::RUN_SLOTS)) begin
         c.run.bytes[c.run.cnt] = b;
         c.run.cnt = c.run.cnt + 3'd1;
      end
      c.st.bw = c.st.bw + 10'd1;
      return c;
   endfunction

   function automatic ctx_type finish_str(ctx_type c);
      if (c.run.cnt < 3'(jsu_pkg::RUN_SLOTS)) begin
         c.run.bytes[c.run.cnt] = CH_NUL;
         c.run.cnt = c.run.cnt + 3'd1;
      end
      c.run.fin  = 1'b1;
      c.run.fovf = c.st.ovf;
      c.st       = '0;
      c.st.mode  = MODE_NORMAL;
      return c;
   endfunction

   function automatic ctx_type emit_q(ctx_type c, logic [9:0] cap);
      if (c.st.bw < cap) c = put_byte(c, CH_QUEST);
      return c;
   endfunction

   function automatic ctx_type clear_hex(ctx_type c);
      c.st.acc   = '0;
      c.st.seen  = '0;
      c.st.hcase = '0;
      return c;
   endfunction

   function automatic ctx_type on_content(ctx_type c, logic [7:0] b, logic [9:0] cap);
      if (b == CH_NUL || b == CH_QUOTE) begin
         c = finish_str(c);
      end else if (c.st.bw >= cap) begin
         c.st.ovf  = 1'b1;
         c.st.mode = (b == CH_BSLASH) ? MODE_SKIP_ESC : MODE_SKIP;
      end else if (b == CH_BSLASH) begin
         c.st.mode = MODE_ESC;
      end else begin
         c = put_byte(c, b);
      end
      return c;
   endfunction

   function automatic ctx_type on_esc(ctx_type c, logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (b == CH_NUL) begin
         c = put_byte(c, CH_BSLASH);
         c = finish_str(c);
      end else if (b == CH_LOW_U) begin
         c.st.mode = MODE_HI;
         c = clear_hex(c);
      end else begin
         if (b == CH_LOW_N)      v = CH_LF;
         else if (b == CH_LOW_R) v = CH_CR;
         else if (b == CH_LOW_T) v = CH_TAB;
         c.st.mode = MODE_NORMAL;
         c = put_byte(c, v);
      end
      return c;
   endfunction

   function automatic ctx_type dispatch(ctx_type c, logic [7:0] b, logic [9:0] cap);
      unique case (c.st.mode)
         MODE_ESC: begin
            c = on_esc(c, b);
         end
         MODE_SKIP: begin
            if (b == CH_NUL || b == CH_QUOTE) c = finish_str(c);
            else if (b == CH_BSLASH)          c.st.mode = MODE_SKIP_ESC;
         end
         MODE_SKIP_ESC: begin
            if (b == CH_NUL) c = finish_str(c);
            else             c.st.mode = MODE_SKIP;
         end
         default: begin
            c = on_content(c, b, cap);
         end
      endcase
      return c;
   endfunction

   // {ok, value}
   function automatic logic [4:0] hex_val(logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h61) + 4'd10};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h41) + 4'd10};
      return r;
   endfunction

   function automatic ctx_type encode(ctx_type c, logic [20:0] cp, logic [9:0] cap);
      logic [2:0]  n;
      logic [10:0] need;
      if (cp <= 21'h7F)        n = 3'd1;
      else if (cp <= 21'h7FF)  n = 3'd2;
      else if (cp <= 21'hFFFF) n = 3'd3;
      else                     n = 3'd4;
      need = {1'b0, c.st.bw} + {8'h00, n};
      if (need > {1'b0, cap}) begin
         c.st.ovf  = 1'b1;
         c.st.mode = MODE_SKIP;
      end else begin
         c.st.mode = MODE_NORMAL;
         unique case (n)
            3'd1: begin
               c = put_byte(c, cp[7:0]);
            end
            3'd2: begin
               c = put_byte(c, 8'hC0 | {3'b000, cp[10:6]});
               c = put_byte(c, 8'h80 | {2'b00, cp[5:0]});
            end
            3'd3: begin
               c = put_byte(c, 8'hE0 | {4'h0, cp[15:12]});
               c = put_byte(c, 8'h80 | {2'b00, cp[11:6]});
               c = put_byte(c, 8'h80 | {2'b00, cp[5:0]});
            end
            default: begin
               c = put_byte(c, 8'hF0 | {5'b00000, cp[20:18]});
               c = put_byte(c, 8'h80 | {2'b00, cp[17:12]});
               c = put_byte(c, 8'h80 | {2'b00, cp[11:6]});
               c = put_byte(c, 8'h80 | {2'b00, cp[5:0]});
            end
         endcase
      end
      return c;
   endfunction

   // emit '?', replay the digits taken so far as plain content, then the bad byte
   function automatic ctx_type bad_digit(ctx_type c, logic [7:0] b, logic [9:0] cap);
      logic [1:0]  n;
      logic [15:0] acc;
      logic [3:0]  cs;
      logic [1:0]  sh;
      logic [3:0]  d;
      logic [7:0]  ch;
      n   = c.st.seen[1:0];
      acc = c.st.acc;
      cs  = c.st.hcase;
      c = emit_q(c, cap);
      c.st.mode = MODE_NORMAL;
      c = clear_hex(c);
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < n) begin
            sh = n - 2'(i) - 2'd1;
            d  = 4'(acc >> {sh, 2'b00});
            if (d < 4'd10) ch = 8'h30 + {4'h0, d};
            else           ch = (cs[2'(i)] ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
            c = dispatch(c, ch, cap);
         end
      end
      c = dispatch(c, b, cap);
      return c;
   endfunction

   function automatic ctx_type on_hex(ctx_type c, logic [7:0] b, logic low,
                                      logic [9:0] cap);
      logic [4:0]  hv;
      logic [15:0] cp;
      hv = hex_val(b);
      if (!hv[4]) begin
         c = bad_digit(c, b, cap);
      end else begin
         if (b >= 8'h41 && b <= 8'h46) c.st.hcase[c.st.seen[1:0]] = 1'b1;
         c.st.acc  = {c.st.acc[11:0], hv[3:0]};
         c.st.seen = c.st.seen + 3'd1;
         if (c.st.seen >= 3'd4) begin
            cp = c.st.acc;
            c = clear_hex(c);
            if (low) begin
               if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                  c = encode(c, 21'h10000 + {1'b0, c.st.phigh, 10'h000}
                                 + {11'h000, cp[9:0]}, cap);
               end else begin
                  c = emit_q(c, cap);
                  c.st.mode = MODE_NORMAL;
               end
               c.st.phigh = '0;
            end else if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
               c.st.phigh = cp[9:0];
               c.st.mode  = MODE_AFTER_HI;
            end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
               c = emit_q(c, cap);
               c.st.mode = MODE_NORMAL;
            end else begin
               c = encode(c, {5'b00000, cp}, cap);
            end
         end
      end
      return c;
   endfunction

   function automatic ctx_type step(ctx_type c, logic [7:0] b, logic [9:0] cap);
      unique case (c.st.mode)
         MODE_HI: begin
            c = on_hex(c, b, 1'b0, cap);
         end
         MODE_LO: begin
            c = on_hex(c, b, 1'b1, cap);
         end
         MODE_AFTER_HI: begin
            if (b == CH_BSLASH) begin
               c.st.mode = MODE_AFTER_HI_ESC;
            end else begin
               c = emit_q(c, cap);
               c.st.mode  = MODE_NORMAL;
               c.st.phigh = '0;
               c = dispatch(c, b, cap);
            end
         end
         MODE_AFTER_HI_ESC: begin
            if (b == CH_LOW_U) begin
               c.st.mode = MODE_LO;
               c = clear_hex(c);
            end else begin
               c = emit_q(c, cap);
               c.st.mode  = MODE_NORMAL;
               c.st.phigh = '0;
               c = on_content(c, CH_BSLASH, cap);
               c = dispatch(c, b, cap);
            end
         end
         default: begin
            c = dispatch(c, b, cap);
         end
      endcase
      return c;
   endfunction

   scan_type   state_ff;
   scan_type   state_in;
   ctx_type    ctx;
   logic [9:0] cap;
   logic       accept;

   assign req_stall = fifo_stat.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cap = (max_length > 10'(CAP_CEIL)) ? 10'(CAP_CEIL) : max_length;
      ctx.st  = state_ff;
      ctx.run = '0;
      ctx = step(ctx, req_in_byte, cap);
      state_in = ctx.st;
      push_run = ctx.run;
      // drop runs with no word in them
      push     = accept && (ctx.run.cnt != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/jsu_run_fifo.sv -----
`timescale 1ns / 1ps

module jsu_run_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  jsu_pkg::run_type          push_run,
   input  logic                      pop,
   output jsu_pkg::run_type          pop_run,
   output jsu_pkg::fifo_status_type  stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   jsu_pkg::run_type mem [DEPTH];

   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign pop_run    = mem[rd_ff];
   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop)      cnt_in = cnt_ff + CW'(1);
      else if (!push && pop) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/jsu_drain.sv -----
`timescale 1ns / 1ps

module jsu_drain (
   input  logic                      clock,
   input  logic                      reset,
   input  jsu_pkg::fifo_status_type  fifo_stat,
   output logic                      pop,
   input  jsu_pkg::run_type          pop_run,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_string_end,
   output logic                      rsp_overflow_flag,
   output logic                      rsp_run_last
);

   logic             have_ff, have_in;
   logic [2:0]       idx_ff, idx_in;
   jsu_pkg::run_type run_ff, run_in;

   logic last;
   logic take;
   logic free;
   logic is_end;

   assign last   = (idx_ff == run_ff.cnt - 3'd1);
   assign take   = have_ff && !rsp_stall;
   // the holding register frees up once its last word leaves
   assign free   = !have_ff || (take && last);
   assign pop    = free && !fifo_stat.empty;
   assign is_end = run_ff.fin && last;

   always_comb begin
      have_in = pop || !free;
      run_in  = pop ? pop_run : run_ff;
      if (pop)       idx_in = '0;
      else if (take) idx_in = idx_ff + 3'd1;
      else           idx_in = idx_ff;
   end

   assign rsp_valid         = have_ff;
   assign rsp_out_byte      = run_ff.bytes[idx_ff];
   assign rsp_byte_valid    = !is_end;
   assign rsp_string_end    = is_end;
   assign rsp_overflow_flag = is_end && run_ff.fovf;
   assign rsp_run_last      = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         have_ff <= have_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

endmodule

// ----- rtl/jsu_port_checker.sv -----
`timescale 1ns / 1ps

module jsu_port_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_stall,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_string_end,
   input  logic        rsp_overflow_flag,
   input  logic        rsp_run_last
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_string_end) && $stable(rsp_run_last))
      else $error("stalled rsp word changed");

   // the closing word carries no byte and ends its run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> !rsp_byte_valid && rsp_run_last)
      else $error("string end word malformed");

   a_ovf_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_flag |-> rsp_string_end)
      else $error("overflow flag outside string end");

   // reset empties the queue and the drain register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state left after reset");

endmodule

bind json_string_unescape_utf8_top jsu_port_checker u_port_checker (.*);
